/* rtl/bmss_pkg.sv */
// Package for the 8x8 block mean / mean-of-squares statistics unit.
// Widths, shifts, saturation limits and shared types. No dependencies.

package bmss_pkg;

    localparam int PIX_W         = 8;
    localparam int PIX_PER_ROW   = 8;
    localparam int BLK_W         = 2;

    // one row: 8 * 255 and 8 * 255^2
    localparam int ROW_SUM_W     = 11;
    localparam int ROW_SQ_W      = 19;

    localparam int PSUM_W        = 13;
    localparam int SQSUM_W       = 21;

    localparam int MEAN_SHIFT    = 3;
    localparam int SQUARE_SHIFT  = 11;
    localparam int MEAN_W        = PSUM_W + MEAN_SHIFT;
    localparam int SQUARE_W      = SQSUM_W + SQUARE_SHIFT;

    localparam logic [PSUM_W-1:0]  PSUM_MAX  = '1;
    localparam logic [SQSUM_W-1:0] SQSUM_MAX = '1;

    localparam int DEFAULT_BLOCK_COUNT = 4;

    typedef logic [PIX_PER_ROW-1:0][PIX_W-1:0] pix_row_t;

    // accumulator bank request from the input stage
    typedef struct packed {
        logic             en;
        logic [BLK_W-1:0] blk;
        logic             last;
    } acc_req_t;

endpackage

/* rtl/bmss_row_if.sv */
// Input channel: one 8-pixel row segment with block index and last-row mark.
// Depends on bmss_pkg.

interface bmss_row_if;
    logic                            valid;
    logic                            ready;
    logic [bmss_pkg::PIX_W-1:0]      pixel_0;
    logic [bmss_pkg::PIX_W-1:0]      pixel_1;
    logic [bmss_pkg::PIX_W-1:0]      pixel_2;
    logic [bmss_pkg::PIX_W-1:0]      pixel_3;
    logic [bmss_pkg::PIX_W-1:0]      pixel_4;
    logic [bmss_pkg::PIX_W-1:0]      pixel_5;
    logic [bmss_pkg::PIX_W-1:0]      pixel_6;
    logic [bmss_pkg::PIX_W-1:0]      pixel_7;
    logic [bmss_pkg::BLK_W-1:0]      block_index;
    logic                            last_row;

    modport source (
        output valid, pixel_0, pixel_1, pixel_2, pixel_3,
               pixel_4, pixel_5, pixel_6, pixel_7, block_index, last_row,
        input  ready
    );

    modport sink (
        input  valid, pixel_0, pixel_1, pixel_2, pixel_3,
               pixel_4, pixel_5, pixel_6, pixel_7, block_index, last_row,
        output ready
    );
endinterface

/* rtl/bmss_stats_if.sv */
// Output channel: scaled pixel sum and square sum of one finished block.
// Depends on bmss_pkg.

interface bmss_stats_if;
    logic                            valid;
    logic                            ready;
    logic [bmss_pkg::BLK_W-1:0]      block_out;
    logic [bmss_pkg::MEAN_W-1:0]     mean_scaled;
    logic [bmss_pkg::SQUARE_W-1:0]   square_scaled;

    modport source (
        output valid, block_out, mean_scaled, square_scaled,
        input  ready
    );

    modport sink (
        input  valid, block_out, mean_scaled, square_scaled,
        output ready
    );
endinterface

/* rtl/bmss_row_sum.sv */
// Row reduction: sum of the eight pixels and sum of their squares.
// Depends on bmss_pkg.

module bmss_row_sum (
    input  bmss_pkg::pix_row_t                pix,
    output logic [bmss_pkg::ROW_SUM_W-1:0]    row_sum,
    output logic [bmss_pkg::ROW_SQ_W-1:0]     row_sq
);

    logic [2*bmss_pkg::PIX_W-1:0] sq [bmss_pkg::PIX_PER_ROW];

    always_comb
    begin
        for (int i = 0; i < bmss_pkg::PIX_PER_ROW; i++)
        begin
            sq[i] = (2*bmss_pkg::PIX_W)'(pix[i]) * (2*bmss_pkg::PIX_W)'(pix[i]);
        end
    end

    // balanced adder trees
    always_comb
    begin
        row_sum = ((bmss_pkg::ROW_SUM_W'(pix[0]) + bmss_pkg::ROW_SUM_W'(pix[1]))
                 + (bmss_pkg::ROW_SUM_W'(pix[2]) + bmss_pkg::ROW_SUM_W'(pix[3])))
                + ((bmss_pkg::ROW_SUM_W'(pix[4]) + bmss_pkg::ROW_SUM_W'(pix[5]))
                 + (bmss_pkg::ROW_SUM_W'(pix[6]) + bmss_pkg::ROW_SUM_W'(pix[7])));
        row_sq  = ((bmss_pkg::ROW_SQ_W'(sq[0]) + bmss_pkg::ROW_SQ_W'(sq[1]))
                 + (bmss_pkg::ROW_SQ_W'(sq[2]) + bmss_pkg::ROW_SQ_W'(sq[3])))
                + ((bmss_pkg::ROW_SQ_W'(sq[4]) + bmss_pkg::ROW_SQ_W'(sq[5]))
                 + (bmss_pkg::ROW_SQ_W'(sq[6]) + bmss_pkg::ROW_SQ_W'(sq[7])));
    end

endmodule

/* rtl/bmss_acc_bank.sv */
// Per-block saturating accumulators for pixel sum and square sum.
// Gives the updated totals combinationally; clears a block after its last row.
// Depends on bmss_pkg.

module bmss_acc_bank #(
    parameter int BLOCK_COUNT = bmss_pkg::DEFAULT_BLOCK_COUNT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bmss_pkg::acc_req_t                req,
    input  logic [bmss_pkg::ROW_SUM_W-1:0]    row_sum,
    input  logic [bmss_pkg::ROW_SQ_W-1:0]     row_sq,
    output logic                              in_range,
    output logic [bmss_pkg::PSUM_W-1:0]       total_sum,
    output logic [bmss_pkg::SQSUM_W-1:0]      total_sq
);

    logic [bmss_pkg::PSUM_W-1:0]  psum_reg  [BLOCK_COUNT];
    logic [bmss_pkg::SQSUM_W-1:0] sqsum_reg [BLOCK_COUNT];

    logic [bmss_pkg::PSUM_W-1:0]  cur_sum;
    logic [bmss_pkg::SQSUM_W-1:0] cur_sq;
    logic [bmss_pkg::PSUM_W:0]    sum_wide;
    logic [bmss_pkg::SQSUM_W:0]   sq_wide;

    always_comb
    begin
        cur_sum = '0;
        cur_sq  = '0;
        for (int i = 0; i < BLOCK_COUNT; i++)
        begin
            if (int'(req.blk) == i)
            begin
                cur_sum = psum_reg[i];
                cur_sq  = sqsum_reg[i];
            end
        end
        in_range = int'(req.blk) < BLOCK_COUNT;
    end

    always_comb
    begin
        sum_wide  = (bmss_pkg::PSUM_W+1)'(cur_sum) + (bmss_pkg::PSUM_W+1)'(row_sum);
        sq_wide   = (bmss_pkg::SQSUM_W+1)'(cur_sq) + (bmss_pkg::SQSUM_W+1)'(row_sq);
        total_sum = sum_wide[bmss_pkg::PSUM_W]  ? bmss_pkg::PSUM_MAX
                                                 : sum_wide[bmss_pkg::PSUM_W-1:0];
        total_sq  = sq_wide[bmss_pkg::SQSUM_W]  ? bmss_pkg::SQSUM_MAX
                                                 : sq_wide[bmss_pkg::SQSUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BLOCK_COUNT; i++)
            begin
                psum_reg[i]  <= '0;
                sqsum_reg[i] <= '0;
            end
        end
        else if (req.en)
        begin
            for (int i = 0; i < BLOCK_COUNT; i++)
            begin
                if (int'(req.blk) == i)
                begin
                    psum_reg[i]  <= req.last ? '0 : total_sum;
                    sqsum_reg[i] <= req.last ? '0 : total_sq;
                end
            end
        end
    end

endmodule

/* rtl/block_mean_square_stats_8x8.sv */
// Top level of the 8x8 block mean / mean-of-squares statistics unit.
// Depends on bmss_pkg, bmss_row_if, bmss_stats_if, bmss_row_sum, bmss_acc_bank.
//
//   channel    | dir | transaction
//   -----------+-----+-----------------------------------------------------
//   row_in     | in  | 8 pixels, block_index, last_row
//   stats_out  | out | block_out, mean_scaled (sum<<3), square_scaled (sq<<11)
//
// One row per cycle while no result is stalled. Path: input register, then
// squares, adder tree and saturating accumulate into the output register.
// Rows that give no result never wait on stats_out. Reset clears all
// accumulators at once. A stalled result holds the input stage only when that
// stage holds a last row.

module block_mean_square_stats_8x8 #(
    parameter int BLOCK_COUNT = bmss_pkg::DEFAULT_BLOCK_COUNT
) (
    input  logic           clk,
    input  logic           rst_n,
    bmss_row_if.sink       row_in,
    bmss_stats_if.source   stats_out
);

    logic                          s1_valid_reg;
    bmss_pkg::pix_row_t            s1_pix_reg;
    logic [bmss_pkg::BLK_W-1:0]    s1_blk_reg;
    logic                          s1_last_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [bmss_pkg::BLK_W-1:0]    out_blk_reg;
    logic [bmss_pkg::MEAN_W-1:0]   out_mean_reg;
    logic [bmss_pkg::SQUARE_W-1:0] out_sq_reg;

    logic [bmss_pkg::ROW_SUM_W-1:0] row_sum;
    logic [bmss_pkg::ROW_SQ_W-1:0]  row_sq;
    logic                           in_range;
    logic [bmss_pkg::PSUM_W-1:0]    total_sum;
    logic [bmss_pkg::SQSUM_W-1:0]   total_sq;
    bmss_pkg::acc_req_t             acc_req;

    logic s1_has_result;
    logic out_free;
    logic s1_advance;
    logic in_xfer;

    assign s1_has_result = s1_valid_reg && s1_last_reg && in_range;
    assign out_free      = !out_valid_reg || stats_out.ready;
    assign s1_advance    = s1_valid_reg && (!s1_has_result || out_free);
    assign row_in.ready  = !s1_valid_reg || s1_advance;
    assign in_xfer       = row_in.valid && row_in.ready;

    always_comb
    begin
        acc_req.en   = s1_advance && in_range;
        acc_req.blk  = s1_blk_reg;
        acc_req.last = s1_last_reg;
    end

    bmss_row_sum u_row_sum (
        .pix     (s1_pix_reg),
        .row_sum (row_sum),
        .row_sq  (row_sq)
    );

    bmss_acc_bank #(
        .BLOCK_COUNT (BLOCK_COUNT)
    ) u_acc_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (acc_req),
        .row_sum   (row_sum),
        .row_sq    (row_sq),
        .in_range  (in_range),
        .total_sum (total_sum),
        .total_sq  (total_sq)
    );

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (row_in.ready)
        begin
            s1_valid_reg <= row_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_pix_reg <= {row_in.pixel_7, row_in.pixel_6, row_in.pixel_5, row_in.pixel_4,
                           row_in.pixel_3, row_in.pixel_2, row_in.pixel_1, row_in.pixel_0};
            s1_blk_reg  <= row_in.block_index;
            s1_last_reg <= row_in.last_row;
        end
    end

    // output register
    always_comb
    begin
        if (s1_advance && s1_has_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (stats_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_has_result)
        begin
            out_blk_reg  <= s1_blk_reg;
            out_mean_reg <= {total_sum, bmss_pkg::MEAN_SHIFT'(0)};
            out_sq_reg   <= {total_sq, bmss_pkg::SQUARE_SHIFT'(0)};
        end
    end

    assign stats_out.valid         = out_valid_reg;
    assign stats_out.block_out     = out_blk_reg;
    assign stats_out.mean_scaled   = out_mean_reg;
    assign stats_out.square_scaled = out_sq_reg;

endmodule

/* dv/bmss_stats_checker.sv */
// Checker for block_mean_square_stats_8x8: watches the row and stats channels,
// predicts each block's scaled sums and compares them with the results it sees.
// Depends on bmss_pkg, bmss_row_if, bmss_stats_if.

module bmss_stats_checker #(
    parameter int BLOCK_COUNT = bmss_pkg::DEFAULT_BLOCK_COUNT
) (
    input  logic        clk,
    input  logic        rst_n,
    bmss_row_if         rows,
    bmss_stats_if       stats,
    output int unsigned fail_count,
    output int unsigned pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [bmss_pkg::BLK_W-1:0]    blk;
        logic [bmss_pkg::MEAN_W-1:0]   mean;
        logic [bmss_pkg::SQUARE_W-1:0] square;
    } block_stat_t;

    logic [bmss_pkg::PSUM_W-1:0]  pix_total [BLOCK_COUNT];
    logic [bmss_pkg::SQSUM_W-1:0] sq_total  [BLOCK_COUNT];
    block_stat_t                  stats_due [$];

    always @(posedge clk or negedge rst_n)
    begin : watch
        block_stat_t                got;
        block_stat_t                want;
        int unsigned                errs;
        int unsigned                row_sum;
        int unsigned                row_sq;
        int unsigned                psum;
        int unsigned                qsum;
        int                         b;
        logic [bmss_pkg::PIX_W-1:0] px [bmss_pkg::PIX_PER_ROW];

        if (!rst_n)
        begin
            for (int i = 0; i < BLOCK_COUNT; i++)
            begin
                pix_total[i] = '0;
                sq_total[i]  = '0;
            end
            stats_due.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            errs = 0;

            // result transaction: compare against the oldest prediction
            if (stats.valid && stats.ready)
            begin
                got.blk    = stats.block_out;
                got.mean   = stats.mean_scaled;
                got.square = stats.square_scaled;
                if (stats_due.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual block %0d mean %0d square %0d",
                             $time, got.blk, got.mean, got.square);
                    errs++;
                end
                else
                begin
                    want = stats_due.pop_front();
                    if (got.blk !== want.blk)
                    begin
                        $display("%0t: block_out mismatch: expected %0d, actual %0d",
                                 $time, want.blk, got.blk);
                        errs++;
                    end
                    if (got.mean !== want.mean)
                    begin
                        $display("%0t: mean_scaled mismatch (block %0d): expected %0d, actual %0d",
                                 $time, want.blk, want.mean, got.mean);
                        errs++;
                    end
                    if (got.square !== want.square)
                    begin
                        $display("%0t: square_scaled mismatch (block %0d): expected %0d, actual %0d",
                                 $time, want.blk, want.square, got.square);
                        errs++;
                    end
                end
            end

            // row transaction: accumulate, emit a prediction on the last row
            if (rows.valid && rows.ready && (rows.block_index < BLOCK_COUNT))
            begin
                b = int'(rows.block_index);
                px[0] = rows.pixel_0;
                px[1] = rows.pixel_1;
                px[2] = rows.pixel_2;
                px[3] = rows.pixel_3;
                px[4] = rows.pixel_4;
                px[5] = rows.pixel_5;
                px[6] = rows.pixel_6;
                px[7] = rows.pixel_7;
                row_sum = 0;
                row_sq  = 0;
                for (int k = 0; k < bmss_pkg::PIX_PER_ROW; k++)
                begin
                    row_sum += 32'(px[k]);
                    row_sq  += 32'(px[k]) * 32'(px[k]);
                end

                // saturating accumulate
                psum = 32'(pix_total[b]) + row_sum;
                qsum = 32'(sq_total[b]) + row_sq;
                if (psum > 32'(bmss_pkg::PSUM_MAX))
                    psum = 32'(bmss_pkg::PSUM_MAX);
                if (qsum > 32'(bmss_pkg::SQSUM_MAX))
                    qsum = 32'(bmss_pkg::SQSUM_MAX);
                pix_total[b] = psum[bmss_pkg::PSUM_W-1:0];
                sq_total[b]  = qsum[bmss_pkg::SQSUM_W-1:0];

                if (rows.last_row)
                begin
                    want.blk    = rows.block_index;
                    want.mean   = bmss_pkg::MEAN_W'(pix_total[b]) << bmss_pkg::MEAN_SHIFT;
                    want.square = bmss_pkg::SQUARE_W'(sq_total[b]) << bmss_pkg::SQUARE_SHIFT;
                    stats_due.push_back(want);
                    pix_total[b] = '0;
                    sq_total[b]  = '0;
                end
            end

            fail_count <= fail_count + errs;
            pending    <= unsigned'(stats_due.size());
        end
    end

endmodule

/* dv/block_mean_square_stats_8x8_test.sv */
// Testbench top for block_mean_square_stats_8x8: clock, reset, row stimulus,
// random back-pressure on the stats channel and the final verdict.
// Depends on bmss_pkg, both channel interfaces and bmss_stats_checker.

module block_mean_square_stats_8x8_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BLOCKS  = bmss_pkg::DEFAULT_BLOCK_COUNT;
    localparam int RANDOM_ROWS = 1830;

    logic        clk;
    logic        rst_n;
    bit          no_idle;
    int unsigned fail_count;
    int unsigned pending;

    bmss_row_if   row_ch ();
    bmss_stats_if stats_ch ();

    block_mean_square_stats_8x8 #(
        .BLOCK_COUNT (NUM_BLOCKS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_in    (row_ch),
        .stats_out (stats_ch)
    );

    bmss_stats_checker #(
        .BLOCK_COUNT (NUM_BLOCKS)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .rows       (row_ch),
        .stats      (stats_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic bmss_pkg::pix_row_t flat_row(input logic [bmss_pkg::PIX_W-1:0] v);
        bmss_pkg::pix_row_t r;
        for (int k = 0; k < bmss_pkg::PIX_PER_ROW; k++)
            r[k] = v;
        return r;
    endfunction

    // 0: uniform, 1: bright (drives saturation on long blocks), 2: black/white, 3: dark
    function automatic bmss_pkg::pix_row_t styled_row(input int style);
        bmss_pkg::pix_row_t r;
        for (int k = 0; k < bmss_pkg::PIX_PER_ROW; k++)
        begin
            case (style)
                1:       r[k] = bmss_pkg::PIX_W'($urandom_range(224, 255));
                2:       r[k] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                3:       r[k] = bmss_pkg::PIX_W'($urandom_range(0, 15));
                default: r[k] = bmss_pkg::PIX_W'($urandom_range(0, 255));
            endcase
        end
        return r;
    endfunction

    // one row transaction; valid stays high across back-to-back rows
    task automatic send_row(input bmss_pkg::pix_row_t px,
                            input logic [bmss_pkg::BLK_W-1:0] blk, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            row_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        row_ch.valid       <= 1'b1;
        row_ch.pixel_0     <= px[0];
        row_ch.pixel_1     <= px[1];
        row_ch.pixel_2     <= px[2];
        row_ch.pixel_3     <= px[3];
        row_ch.pixel_4     <= px[4];
        row_ch.pixel_5     <= px[5];
        row_ch.pixel_6     <= px[6];
        row_ch.pixel_7     <= px[7];
        row_ch.block_index <= blk;
        row_ch.last_row    <= last;
        do
            @(posedge clk);
        while (!row_ch.ready);
    endtask

    task automatic drain_results();
        row_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // result side: random stall before each result transaction
    initial
    begin
        int hold;
        stats_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 6);
            if (hold > 0)
            begin
                stats_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            stats_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(stats_ch.valid && stats_ch.ready));
        end
    end

    initial
    begin
        bmss_pkg::pix_row_t         px;
        logic [bmss_pkg::BLK_W-1:0] blk;
        logic                       last;
        int                         rows_open [NUM_BLOCKS];
        int                         target    [NUM_BLOCKS];
        int                         style     [NUM_BLOCKS];
        int                         pick;

        rst_n              = 1'b0;
        no_idle            = 1'b0;
        row_ch.valid       <= 1'b0;
        row_ch.pixel_0     <= '0;
        row_ch.pixel_1     <= '0;
        row_ch.pixel_2     <= '0;
        row_ch.pixel_3     <= '0;
        row_ch.pixel_4     <= '0;
        row_ch.pixel_5     <= '0;
        row_ch.pixel_6     <= '0;
        row_ch.pixel_7     <= '0;
        row_ch.block_index <= '0;
        row_ch.last_row    <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single rows at both extremes
        send_row(flat_row(8'h00), 2'd0, 1'b1);
        send_row(flat_row(8'hFF), 2'd1, 1'b1);
        // four full-white rows: largest sums without saturation
        for (int i = 0; i < 4; i++)
            send_row(flat_row(8'hFF), 2'd2, i == 3);
        // six full-white rows: both accumulators saturate
        for (int i = 0; i < 6; i++)
            send_row(flat_row(8'hFF), 2'd3, i == 5);
        // ramp and alternating bit patterns
        for (int k = 0; k < bmss_pkg::PIX_PER_ROW; k++)
            px[k] = bmss_pkg::PIX_W'(k * 36);
        send_row(px, 2'd0, 1'b0);
        for (int k = 0; k < bmss_pkg::PIX_PER_ROW; k++)
            px[k] = k[0] ? 8'h55 : 8'hAA;
        send_row(px, 2'd0, 1'b1);
        // interleaved blocks
        send_row(flat_row(8'hAA), 2'd1, 1'b0);
        send_row(flat_row(8'h55), 2'd2, 1'b0);
        send_row(flat_row(8'h80), 2'd1, 1'b1);
        send_row(flat_row(8'h01), 2'd2, 1'b1);

        drain_results();

        // random: mostly four-row blocks, some short, some overlong
        for (int b = 0; b < NUM_BLOCKS; b++)
        begin
            rows_open[b] = 0;
            target[b]    = 4;
            style[b]     = 0;
        end
        for (int n = 0; n < RANDOM_ROWS; n++)
        begin
            if (n % 150 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ROWS / 2)
                drain_results();

            blk = bmss_pkg::BLK_W'($urandom_range(0, NUM_BLOCKS - 1));
            if (rows_open[blk] == 0)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    target[blk] = 4;
                else if (pick < 85)
                    target[blk] = $urandom_range(1, 3);
                else
                    target[blk] = $urandom_range(5, 9);
                pick = $urandom_range(0, 9);
                style[blk] = (pick < 5) ? 0 : (pick < 7) ? 1 : (pick < 9) ? 2 : 3;
            end
            last = (rows_open[blk] + 1 >= target[blk]);
            send_row(styled_row(style[blk]), blk, last);
            rows_open[blk] = last ? 0 : rows_open[blk] + 1;
        end

        row_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (10) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
